/* src/assert_macros.svh */
// assertion macros shared by the trigger detector rtl
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define BET_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// expression must never be true out of reset
`define BET_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define BET_ASSERT(label, clk, rst_n, prop)
`define BET_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* src/bet_pkg.sv */
// shared types and constants of the button event trigger
// no dependencies
package bet_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_W       = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_KIND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_RECURSIVE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_IVAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DUR      = 3'd4;

    localparam logic [3:0] K_CLICK         = 4'd0;
    localparam logic [3:0] K_RCLICK        = 4'd1;
    localparam logic [3:0] K_HOVER_START   = 4'd2;
    localparam logic [3:0] K_HOVER_END     = 4'd3;
    localparam logic [3:0] K_PRESS_START   = 4'd4;
    localparam logic [3:0] K_PRESS_END     = 4'd5;
    localparam logic [3:0] K_RPRESS_START  = 4'd6;
    localparam logic [3:0] K_RPRESS_END    = 4'd7;
    localparam logic [3:0] K_PRESS_REPEAT  = 4'd8;
    localparam logic [3:0] K_PRESS_HOLD    = 4'd9;
    localparam logic [3:0] K_RPRESS_REPEAT = 4'd10;
    localparam logic [3:0] K_RPRESS_HOLD   = 4'd11;
    localparam logic [3:0] K_NONE          = 4'd12;

    typedef enum logic [1:0] {
        LVL_UNKNOWN = 2'd0,
        LVL_LOW     = 2'd1,
        LVL_HIGH    = 2'd2
    } t_level;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_DIVN_GO,
        S_DIVN_WAIT,
        S_DIVP_GO,
        S_DIVP_WAIT,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic load;
        logic accum;
        logic div_start;
        logic div_prev;
        logic save_q;
        logic eval;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_stat;

endpackage

/* src/button_event_trigger.sv */
// top level of the button event trigger: stream ports, config port, ctrl and datapath
// depends on bet_pkg, bet_ctrl, bet_datapath
//
// Takes one frame per input transaction (pointer flags and the milliseconds since the
// previous frame) and returns one transaction whose bit 0 says whether the configured
// trigger fires. After acceptance a frame passes through the ACCUM and EVAL states in
// every mode except a repeat mode with the button still held and a nonzero interval;
// there one shared restoring divider, one quotient bit per cycle, gives the tick counts
// of the current and the previous watch time in turn, between ACCUM and EVAL. A new
// frame is taken as soon as the previous one has been placed in the output register,
// even while that result still waits to be taken. The user must write configuration
// only while no frame is in flight; the block itself does not enforce it.
module button_event_trigger
    import bet_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // clicked, right_clicked, hovered, pressed, right_pressed, pressed_hover,
    // right_pressed_hover, elapsed_ms[15:0], one pad bit
    input  logic [23:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // fire, seven pad bits
    output logic [7:0]            m_axis_tdata,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     fire;

    bet_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(s_axis_tvalid),
        .o_s_ready(s_axis_tready),
        .o_m_valid(m_axis_tvalid),
        .i_m_ready(m_axis_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    bet_datapath #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (s_axis_tdata[IN_W-1:0]),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_fire     (fire)
    );

    assign m_axis_tdata = {7'b0, fire};

endmodule

/* src/bet_div.sv */
// restoring divider, one quotient bit per cycle, 16-bit divisor
// depends on nothing but its parameter
module bet_div #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TIME_WIDTH-1:0] i_numer,
    input  logic [15:0]           i_denom,
    output logic                  o_done,
    output logic [TIME_WIDTH-1:0] o_quot
);

    localparam int CW = $clog2(TIME_WIDTH + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [TIME_WIDTH-1:0] r_quot;
    logic [15:0]           r_rem;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_quot[TIME_WIDTH-1]};
        ge    = trial >= {1'b0, i_denom};
        diff  = trial - {1'b0, i_denom};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(TIME_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator shifts out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_numer;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[TIME_WIDTH-2:0], ge};
            r_rem  <= ge ? diff[15:0] : trial[15:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* src/bet_datapath.sv */
// datapath: config registers, level memories, stopwatches, repeat and hold logic
// depends on bet_pkg and bet_div
module bet_datapath
    import bet_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [IN_W-1:0]       i_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_fire
);

    localparam int TW1 = TIME_WIDTH + 1;

    // configuration
    logic [3:0]  r_kind;
    logic        r_use_rec;
    logic [15:0] r_ival;
    logic [15:0] r_first;
    logic [15:0] r_hold_dur;

    // captured frame
    logic        r_clicked;
    logic        r_rclicked;
    logic        r_hovered;
    logic        r_pressed;
    logic        r_rpressed;
    logic        r_press_hov;
    logic        r_rpress_hov;
    logic [15:0] r_elapsed;

    // state
    t_level                r_level [6];
    logic [3:0]            r_run;
    logic [TIME_WIDTH-1:0] r_time [4];
    logic [TIME_WIDTH-1:0] r_prev [2];
    logic [1:0]            r_done;

    logic [TIME_WIDTH-1:0] r_q_now;
    logic                  r_fire;

    // eval results
    t_level                e_level [6];
    logic [3:0]            e_run;
    logic [TIME_WIDTH-1:0] e_time [4];
    logic [TIME_WIDTH-1:0] e_prev [2];
    logic [1:0]            e_done;
    logic                  e_fire;

    logic                  pair;
    logic [1:0]            rep_w;
    logic [1:0]            hold_w;
    logic                  held;
    logic [15:0]           first_ms;
    logic [TIME_WIDTH-1:0] first_ext;
    logic [TIME_WIDTH-1:0] div_numer;
    logic                  div_done;
    logic [TIME_WIDTH-1:0] div_quot;
    logic                  is_repeat;
    logic                  now_ge;
    logic                  prev_ge;
    logic                  rep_fire;
    logic [TW1-1:0]        sum [4];

    assign pair      = r_kind[1];
    assign rep_w     = {r_kind[1], 1'b0};
    assign hold_w    = {r_kind[1], 1'b1};
    assign held      = pair ? r_rpress_hov : r_press_hov;
    assign first_ms  = (r_first == '0) ? r_ival : r_first;
    assign first_ext = TIME_WIDTH'(first_ms);
    assign is_repeat = (r_kind == K_PRESS_REPEAT) || (r_kind == K_RPRESS_REPEAT);

    assign div_numer = i_cmd.div_prev ? (r_prev[pair] - first_ext)
                                      : (r_time[rep_w] - first_ext);

    bet_div #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_numer(div_numer),
        .i_denom(r_ival),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    assign o_stat.need_div = is_repeat && held && r_run[rep_w] && (r_ival != '0);
    assign o_stat.div_done = div_done;

    // ticks(t) = t >= F ? (t-F)/I + 1 : 0, compared without the +1
    assign now_ge   = r_time[rep_w] >= first_ext;
    assign prev_ge  = r_prev[pair] >= first_ext;
    assign rep_fire = now_ge && (!prev_ge || (r_q_now > div_quot));

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sum[i] = TW1'(r_time[i]) + TW1'(r_elapsed);
        end
    end

    always_comb begin
        logic [1:0]            grp;
        logic [2:0]            lvl_idx;
        logic                  lvl;
        t_level                prev_lvl;
        logic [TIME_WIDTH-1:0] t_hold;
        logic                  done_now;

        for (int i = 0; i < 6; i++) begin
            e_level[i] = LVL_UNKNOWN;
        end
        e_run    = r_run;
        e_time   = r_time;
        e_prev   = r_prev;
        e_done   = r_done;
        e_fire   = 1'b0;
        grp      = r_kind[2:1] - 2'd1;
        lvl_idx  = {grp, r_use_rec};
        prev_lvl = r_level[lvl_idx];
        t_hold   = r_run[hold_w] ? r_time[hold_w] : '0;
        done_now = r_run[hold_w] && r_done[pair];
        unique case (r_kind[2:1])
            2'b01:   lvl = r_hovered;
            2'b10:   lvl = r_pressed;
            default: lvl = r_rpressed;
        endcase

        case (r_kind) inside
            K_CLICK:  e_fire = r_clicked;
            K_RCLICK: e_fire = r_rclicked;
            K_HOVER_START, K_PRESS_START, K_RPRESS_START: begin
                e_fire           = lvl && (prev_lvl == LVL_LOW);
                e_level[lvl_idx] = lvl ? LVL_HIGH : LVL_LOW;
            end
            K_HOVER_END, K_PRESS_END, K_RPRESS_END: begin
                e_fire           = !lvl && (prev_lvl == LVL_HIGH);
                e_level[lvl_idx] = lvl ? LVL_HIGH : LVL_LOW;
            end
            K_PRESS_REPEAT, K_RPRESS_REPEAT: begin
                if (!held || !r_run[rep_w]) begin
                    e_run[rep_w]  = held;
                    e_time[rep_w] = '0;
                    e_prev[pair]  = '0;
                    e_fire        = held;
                end else if (r_ival != '0) begin
                    e_prev[pair] = r_time[rep_w];
                    e_fire       = rep_fire;
                end
            end
            K_PRESS_HOLD, K_RPRESS_HOLD: begin
                if (!held) begin
                    e_run[hold_w]  = 1'b0;
                    e_time[hold_w] = '0;
                    e_done[pair]   = 1'b0;
                end else begin
                    e_run[hold_w]  = 1'b1;
                    e_time[hold_w] = t_hold;
                    e_done[pair]   = done_now;
                    if (!done_now && (t_hold >= TIME_WIDTH'(r_hold_dur))) begin
                        e_done[pair] = 1'b1;
                        e_fire       = 1'b1;
                    end
                end
            end
            K_NONE:  e_fire = 1'b0;
            default: e_fire = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= K_CLICK;
            r_use_rec  <= 1'b0;
            r_ival     <= '0;
            r_first    <= '0;
            r_hold_dur <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_TRIGGER_KIND:  r_kind     <= i_cfg_wdata[3:0];
                CFG_USE_RECURSIVE: r_use_rec  <= i_cfg_wdata[0];
                CFG_REPEAT_IVAL:   r_ival     <= i_cfg_wdata;
                CFG_REPEAT_FIRST:  r_first    <= i_cfg_wdata;
                CFG_HOLD_DUR:      r_hold_dur <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_level[i] <= LVL_UNKNOWN;
            end
            for (int i = 0; i < 4; i++) begin
                r_time[i] <= '0;
            end
            r_prev[0] <= '0;
            r_prev[1] <= '0;
            r_run     <= '0;
            r_done    <= '0;
        end else if (i_cmd.accum) begin
            // running watches advance and saturate in every mode
            for (int i = 0; i < 4; i++) begin
                if (r_run[i]) begin
                    r_time[i] <= sum[i][TIME_WIDTH] ? '1 : sum[i][TIME_WIDTH-1:0];
                end
            end
        end else if (i_cmd.eval) begin
            r_level <= e_level;
            r_run   <= e_run;
            r_time  <= e_time;
            r_prev  <= e_prev;
            r_done  <= e_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clicked    <= i_item[0];
            r_rclicked   <= i_item[1];
            r_hovered    <= i_item[2];
            r_pressed    <= i_item[3];
            r_rpressed   <= i_item[4];
            r_press_hov  <= i_item[5];
            r_rpress_hov <= i_item[6];
            r_elapsed    <= i_item[22:7];
        end
        if (i_cmd.save_q) begin
            r_q_now <= div_quot;
        end
        if (i_cmd.eval) begin
            r_fire <= e_fire;
        end
    end

    assign o_fire = r_fire;

endmodule

/* src/bet_ctrl.sv */
// controller state machine and output valid register
// depends on bet_pkg and assert_macros.svh
`include "assert_macros.svh"

module bet_ctrl
    import bet_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    output logic     o_m_valid,
    input  logic     i_m_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_s_valid) n_state = S_ACCUM;
            S_ACCUM:     n_state = i_stat.need_div ? S_DIVN_GO : S_EVAL;
            S_DIVN_GO:   n_state = S_DIVN_WAIT;
            S_DIVN_WAIT: if (i_stat.div_done) n_state = S_DIVP_GO;
            S_DIVP_GO:   n_state = S_DIVP_WAIT;
            S_DIVP_WAIT: if (i_stat.div_done) n_state = S_EVAL;
            S_EVAL:      if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            S_ACCUM:     o_cmd.accum = 1'b1;
            S_DIVN_GO:   o_cmd.div_start = 1'b1;
            S_DIVN_WAIT: o_cmd.save_q = i_stat.div_done;
            S_DIVP_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_prev  = 1'b1;
            end
            S_DIVP_WAIT: ;
            S_EVAL:      o_cmd.eval = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.eval) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

    `BET_ASSERT(a_load_accum, i_clk, i_rst_n, (r_state == S_IDLE && i_s_valid) |=> (r_state == S_ACCUM))
    `BET_ASSERT(a_div_repeat, i_clk, i_rst_n, (r_state == S_DIVN_GO || r_state == S_DIVP_GO) |-> i_stat.need_div)
    `BET_ASSERT(a_eval_shows, i_clk, i_rst_n, o_cmd.eval |=> (r_out_valid && r_state == S_IDLE))
    `BET_NEVER(a_stray_done, i_clk, i_rst_n, i_stat.div_done && r_state != S_DIVN_WAIT && r_state != S_DIVP_WAIT)

endmodule
